// ===== rtl/core/smpq_pkg.sv =====
// ----------------------------------------------------------------------------
// smpq_pkg
// shared widths, result codes and controller/datapath interface types for the
// stable max priority queue
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int CAPACITY  = 64;
    localparam int PRIO_W    = 16;
    localparam int VALUE_W   = 32;
    localparam int REQ_PRI_W = 16;
    localparam int OCC_W     = 7;
    localparam int STAT_W    = 2;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;     // capture the input transfer
        logic    insert;   // sorted insert of the held entry
        logic    remove;   // drop the head entry
        logic    write;    // update the result register
        status_t code;     // result code for this operation
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic op_deq;
        logic full;
        logic empty;
    } dp_status_t;

endpackage

// ===== rtl/core/smpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// smpq_ctrl
// two-state sequencer: capture an operation, then execute it and post the
// result; also owns the result valid flag
// ----------------------------------------------------------------------------
module smpq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  smpq_pkg::dp_status_t dp_status,
    output smpq_pkg::dp_cmd_t    dp_cmd
);
    import smpq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;

    // result slot must be free (or draining) before a new operation starts
    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        dp_cmd       = '0;
        dp_cmd.code  = ST_OK;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    dp_cmd.load = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                dp_cmd.write = 1'b1;
                if (dp_status.op_deq) begin
                    if (dp_status.empty) begin
                        dp_cmd.code = ST_EMPTY;
                    end else begin
                        dp_cmd.remove = 1'b1;
                    end
                end else begin
                    if (dp_status.full) begin
                        dp_cmd.code = ST_FULL;
                    end else begin
                        dp_cmd.insert = 1'b1;
                    end
                end
                m_valid_next = 1'b1;
                state_next   = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/core/smpq_dpath.sv =====
// ----------------------------------------------------------------------------
// smpq_dpath
// sorted shift-register array with per-cell priority compare, input holding
// registers and the result register
// ----------------------------------------------------------------------------
module smpq_dpath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_op,
    input  logic signed [smpq_pkg::VALUE_W-1:0]   s_value,
    input  logic signed [smpq_pkg::REQ_PRI_W-1:0] s_priority_req,
    input  smpq_pkg::dp_cmd_t                     dp_cmd,
    output smpq_pkg::dp_status_t                  dp_status,
    output logic signed [smpq_pkg::VALUE_W-1:0]   m_out_value,
    output logic [smpq_pkg::STAT_W-1:0]           m_status,
    output logic [smpq_pkg::OCC_W-1:0]            m_occupancy
);
    import smpq_pkg::*;

    logic signed [VALUE_W-1:0] val_reg [CAPACITY];
    logic signed [PRIO_W-1:0]  pri_reg [CAPACITY];
    logic [CNT_W-1:0]          count_reg, count_next;

    logic                      op_reg;
    logic signed [VALUE_W-1:0] in_val_reg;
    logic signed [PRIO_W-1:0]  in_pri_reg;

    logic signed [VALUE_W-1:0] res_value_reg, res_value_next;
    logic [STAT_W-1:0]         res_status_reg;
    logic [OCC_W-1:0]          res_occ_reg;

    logic [CAPACITY-1:0] keep;

    assign dp_status.op_deq = (op_reg == OP_DEQ);
    assign dp_status.full   = (count_reg == CNT_W'(CAPACITY));
    assign dp_status.empty  = (count_reg == '0);

    // a cell keeps its entry when it is occupied and ranks at or above the new one
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
        assign keep[i] = (CNT_W'(i) < count_reg) && (pri_reg[i] >= in_pri_reg);
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        always_ff @(posedge aclk) begin
            if (dp_cmd.insert && !keep[i]) begin
                if (i == 0) begin
                    val_reg[i] <= in_val_reg;
                    pri_reg[i] <= in_pri_reg;
                end else if (keep[(i == 0) ? 0 : i-1]) begin
                    val_reg[i] <= in_val_reg;
                    pri_reg[i] <= in_pri_reg;
                end else begin
                    val_reg[i] <= val_reg[(i == 0) ? 0 : i-1];
                    pri_reg[i] <= pri_reg[(i == 0) ? 0 : i-1];
                end
            end else if (dp_cmd.remove && (i < CAPACITY-1)) begin
                val_reg[i] <= val_reg[(i < CAPACITY-1) ? i+1 : i];
                pri_reg[i] <= pri_reg[(i < CAPACITY-1) ? i+1 : i];
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (dp_cmd.insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (dp_cmd.remove) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        res_value_next = '0;
        if (dp_cmd.remove) begin
            res_value_next = val_reg[0];
        end else if (dp_cmd.code == ST_EMPTY) begin
            res_value_next = '1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.load) begin
            op_reg     <= s_op;
            in_val_reg <= s_value;
            in_pri_reg <= PRIO_W'(s_priority_req);
        end
        if (dp_cmd.write) begin
            res_value_reg  <= res_value_next;
            res_status_reg <= dp_cmd.code;
            res_occ_reg    <= OCC_W'(count_next);
        end
    end

    assign m_out_value = res_value_reg;
    assign m_status    = res_status_reg;
    assign m_occupancy = res_occ_reg;

endmodule

// ===== rtl/core/stable_max_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// stable_max_priority_queue_core
// bounded max priority queue, equal priorities leave in arrival order
//
//   channel   dir   ports                                   meaning
//   s_        in    s_op, s_value, s_priority_req           enqueue / dequeue
//   m_        out   m_out_value, m_status, m_occupancy      one result per op
//
// each operation is captured in S_IDLE; S_EXEC then does the parallel compare
// and one-place shift of the 64-cell sorted register array.
// a new operation is taken while the previous result waits in the output
// register, as long as that result is taken no later than the same edge.
// reset (aresetn low, synchronous) empties the queue; stored entries are not
// cleared, the fill count alone marks them live.
// ----------------------------------------------------------------------------
module stable_max_priority_queue_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_op,
    input  logic signed [smpq_pkg::VALUE_W-1:0]   s_value,
    input  logic signed [smpq_pkg::REQ_PRI_W-1:0] s_priority_req,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [smpq_pkg::VALUE_W-1:0]   m_out_value,
    output logic [smpq_pkg::STAT_W-1:0]           m_status,
    output logic [smpq_pkg::OCC_W-1:0]            m_occupancy
);
    import smpq_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    smpq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    smpq_dpath u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_op           (s_op),
        .s_value        (s_value),
        .s_priority_req (s_priority_req),
        .dp_cmd         (dp_cmd),
        .dp_status      (dp_status),
        .m_out_value    (m_out_value),
        .m_status       (m_status),
        .m_occupancy    (m_occupancy)
    );

`ifndef ASSERT_OFF
    // one operation in flight: no back-to-back input transfers
    a_no_b2b_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an operation was executing");

    // an empty dequeue reports all ones and an empty queue
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_EMPTY)) |-> ((m_out_value == -1) && (m_occupancy == '0)))
        else $error("empty dequeue result malformed");

    // a refused enqueue only happens at full occupancy
    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_FULL)) |-> (m_occupancy == OCC_W'(CAPACITY)))
        else $error("full status with queue not full");

    // an accepted operation passes through S_EXEC, which then sets the registered result valid flag
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> ##1 m_valid)
        else $error("result missing after accepted operation");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives enqueue and dequeue transfers into the stable max priority queue and
// checks every result against a sorted-array predictor: head value, result
// code and fill count, including empty dequeues, full enqueues and the arrival
// order of equal priorities
// ----------------------------------------------------------------------------
module testbench;

    import smpq_pkg::*;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        status_t                   status;
        logic [OCC_W-1:0]          occupancy;
    } pq_result_t;

    typedef enum int {
        PRIO_TIES,
        PRIO_FULL,
        PRIO_EDGES
    } prio_mix_t;

    bit                            aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_op;
    logic signed [VALUE_W-1:0]     s_value;
    logic signed [REQ_PRI_W-1:0]   s_priority_req;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [VALUE_W-1:0]     m_out_value;
    logic [STAT_W-1:0]             m_status;
    logic [OCC_W-1:0]              m_occupancy;

    // predictor state: sorted entries, head at index 0
    logic signed [VALUE_W-1:0]     pq_value [CAPACITY];
    logic signed [PRIO_W-1:0]      pq_prio  [CAPACITY];
    int                            pq_count;

    pq_result_t                    expected_results [$];
    int                            errors;
    bit                            src_idle_en;
    bit                            snk_idle_en;

    stable_max_priority_queue_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_value        (s_value),
        .s_priority_req (s_priority_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_value    (m_out_value),
        .m_status       (m_status),
        .m_occupancy    (m_occupancy)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predicts one operation: sorted insert behind all entries of greater or equal priority, or head removal
    function automatic void apply_queue_op(input logic op,
                                           input logic signed [VALUE_W-1:0] value,
                                           input logic signed [REQ_PRI_W-1:0] prio);
        pq_result_t               res;
        logic signed [PRIO_W-1:0] p;
        int                       pos;
        res.value  = '0;
        res.status = ST_OK;
        if (op == OP_ENQ) begin
            if (pq_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                p   = prio;
                pos = 0;
                while (pos < pq_count && pq_prio[pos] >= p)
                    pos++;
                for (int i = pq_count; i > pos; i--) begin
                    pq_value[i] = pq_value[i-1];
                    pq_prio[i]  = pq_prio[i-1];
                end
                pq_value[pos] = value;
                pq_prio[pos]  = p;
                pq_count++;
            end
        end else begin
            if (pq_count == 0) begin
                res.status = ST_EMPTY;
                res.value  = -1;
            end else begin
                res.value = pq_value[0];
                for (int i = 1; i < pq_count; i++) begin
                    pq_value[i-1] = pq_value[i];
                    pq_prio[i-1]  = pq_prio[i];
                end
                pq_count--;
            end
        end
        res.occupancy = pq_count[OCC_W-1:0];
        expected_results.push_back(res);
    endfunction

    function automatic logic signed [REQ_PRI_W-1:0] pick_priority(input prio_mix_t mix);
        case (mix)
            PRIO_TIES: return REQ_PRI_W'(int'($urandom_range(0, 3)) - 2);
            PRIO_EDGES: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return 16'sh0000;
                    default: return 16'shffff;
                endcase
            end
            default: return REQ_PRI_W'($urandom);
        endcase
    endfunction

    task automatic send_op(input logic op, input logic signed [VALUE_W-1:0] value,
                           input logic signed [REQ_PRI_W-1:0] prio);
        int gap;
        gap = (src_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid        = 1'b0;
            s_op           = 1'($urandom);
            s_value        = $urandom;
            s_priority_req = REQ_PRI_W'($urandom);
            repeat (gap) @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_op           = op;
        s_value        = value;
        s_priority_req = prio;
        do @(posedge aclk); while (!s_ready);
        apply_queue_op(op, value, prio);
    endtask

    task automatic send_random(input int enq_pct, input prio_mix_t mix);
        send_op(($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ, $urandom,
                pick_priority(mix));
    endtask

    task automatic test_empty_dequeue();
        send_op(OP_DEQ, 32'sh7fffffff, 16'sh7fff);
        send_op(OP_DEQ, 32'sh80000000, 16'sh8000);
    endtask

    // extremes of value and priority, three-way tie at priority zero
    task automatic test_order_and_extremes();
        send_op(OP_ENQ, 32'sh7fffffff, 16'sh0000);
        send_op(OP_ENQ, 32'sh80000000, 16'sh8000);
        send_op(OP_ENQ, 32'sh00000001, 16'sh7fff);
        send_op(OP_ENQ, -32'sd1,       16'sh0000);
        send_op(OP_ENQ, 32'sh5a5a5a5a, 16'shffff);
        send_op(OP_ENQ, 32'sha5a5a5a5, 16'sh0000);
        send_op(OP_ENQ, 32'sh00000000, 16'sh7fff);
        repeat (7) send_op(OP_DEQ, $urandom, REQ_PRI_W'($urandom));
        send_op(OP_DEQ, 32'sh00000000, 16'sh0000);
    endtask

    task automatic test_fill_and_overflow();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        for (int i = 0; i < CAPACITY + 3; i++)
            send_op(OP_ENQ, $urandom, pick_priority(i % 2 ? PRIO_TIES : PRIO_EDGES));
        repeat (CAPACITY + 1) send_op(OP_DEQ, $urandom, REQ_PRI_W'($urandom));
    endtask

    // phases that fill toward full, drain toward empty or stay balanced
    task automatic test_random_traffic();
        int        enq_pct;
        prio_mix_t mix;
        for (int phase = 0; phase < 14; phase++) begin
            case ($urandom_range(0, 2))
                0: enq_pct = 80;
                1: enq_pct = 20;
                default: enq_pct = 50;
            endcase
            mix = prio_mix_t'($urandom_range(0, 2));
            src_idle_en = 1'($urandom_range(0, 1));
            snk_idle_en = 1'($urandom_range(0, 1));
            repeat (100) send_random(enq_pct, mix);
        end
    endtask

    task automatic test_steady_stream();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        repeat (150) send_random(60, PRIO_TIES);
        repeat (150) send_random(45, PRIO_FULL);
    endtask

    // sink side: random stall bursts
    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (snk_idle_en && $urandom_range(0, 9) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        pq_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with none expected: out_value %0d status %0d occupancy %0d",
                       m_out_value, m_status, m_occupancy);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (m_out_value !== want.value) begin
                    $error("out_value: expected %0d, actual %0d", want.value, m_out_value);
                    errors++;
                end
                if (m_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_status);
                    errors++;
                end
                if (m_occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, actual %0d", want.occupancy, m_occupancy);
                    errors++;
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_op           = OP_ENQ;
        s_value        = '0;
        s_priority_req = '0;
        pq_count       = 0;
        errors         = 0;
        src_idle_en    = 1'b0;
        snk_idle_en    = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_dequeue();
        test_order_and_extremes();
        test_fill_and_overflow();
        test_random_traffic();
        test_steady_stream();

        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
